### sv/rrs_pkg.sv
// Package: shared constants and types for the round-robin schedule simulator
package rrs_pkg;
  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = $clog2(MaxProcs);
  localparam int unsigned CntW     = $clog2(MaxProcs + 1);
  localparam int unsigned TimeW    = 21;
  localparam int unsigned SumW     = 25;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StScan   = 9'b000000010,
    StChoose = 9'b000000100,
    StPop    = 9'b000001000,
    StRun    = 9'b000010000,
    StFinish = 9'b000100000,
    StEmit   = 9'b001000000,
    StMin    = 9'b010000000,
    StClear  = 9'b100000000
  } rrs_state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic min_start;
    logic min_step;
    logic jump;
    logic pop;
    logic run;
    logic push_cur;
    logic finish;
    logic clear;
  } rrs_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic fifo_empty;
    logic cur_done;
    logic all_done;
  } rrs_sts_t;
endpackage

### sv/rrs_ctrl.sv
// Controller: sequences load, admit scans, turns and result emission
module rrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rrs_pkg::rrs_sts_t sts_i,
  output rrs_pkg::rrs_cmd_t cmd_o
);
  import rrs_pkg::*;

  rrs_state_e state_q, state_d;
  logic       after_q, after_d; // 1: scan follows a finish, go emit

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      after_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_start = 1'b1;
            after_d = 1'b0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = after_q ? StEmit : StChoose;
        end
      end
      StChoose: begin
        if (sts_i.all_done) begin
          state_d = StClear;
        end else if (sts_i.fifo_empty) begin
          cmd_o.min_start = 1'b1;
          state_d = StMin;
        end else begin
          state_d = StPop;
        end
      end
      StMin: begin
        cmd_o.min_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.jump = 1'b1;
          cmd_o.scan_start = 1'b1;
          after_d = 1'b0;
          state_d = StScan;
        end
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StRun;
      end
      StRun: begin
        cmd_o.run = 1'b1;
        cmd_o.scan_start = 1'b1;
        if (sts_i.cur_done) begin
          state_d = StFinish;
        end else begin
          after_d = 1'b0;
          state_d = StScan;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        cmd_o.scan_start = 1'b1;
        after_d = 1'b1;
        state_d = StScan;
      end
      StEmit: begin
        if (out_ready_i) state_d = StChoose;
      end
      StClear: begin
        cmd_o.clear = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // requeue preempted job once its admit scan completes
    if (state_q == StScan && sts_i.scan_done && !after_q && sts_i.cur_done == 1'b0) begin
      cmd_o.push_cur = 1'b1;
    end
  end
endmodule

### sv/rrs_dp.sv
// Datapath: job tables, ready queue, clock and accumulators
module rrs_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           quantum_i,
  input  logic [15:0]           arrival_i,
  input  logic [15:0]           burst_i,
  input  rrs_pkg::rrs_cmd_t     cmd_i,
  output rrs_pkg::rrs_sts_t     sts_o,
  output logic [4:0]            job_id_o,
  output logic [15:0]           job_arrival_o,
  output logic [15:0]           job_burst_o,
  output logic [20:0]           wait_time_o,
  output logic [20:0]           turnaround_o,
  output logic [24:0]           total_wait_o,
  output logic [24:0]           total_turnaround_o,
  output logic                  last_result_o
);
  import rrs_pkg::*;

  logic [15:0] arr_mem [MaxProcs];
  logic [15:0] bur_mem [MaxProcs];
  logic [15:0] rem_mem [MaxProcs];
  logic [IdxW-1:0] fifo_mem [MaxProcs];

  logic [MaxProcs-1:0] adm_q;
  logic [IdxW-1:0]     head_q;
  logic [CntW-1:0]     cnt_q, loaded_q, done_q;
  logic [TimeW-1:0]    now_q, min_q;
  logic                min_ok_q;
  logic [SumW-1:0]     sw_q, st_q;
  logic [CntW-1:0]     scan_q;
  logic [IdxW-1:0]     cur_q;
  logic [15:0]         cur_rem_q;
  logic                cur_live_q;
  logic [15:0]         q_eff;
  logic [IdxW-1:0]     si;
  logic                admit;
  logic [TimeW-1:0]    tat, wt;

  assign q_eff = (quantum_i == 16'd0) ? 16'd1 : quantum_i;
  assign si    = scan_q[IdxW-1:0];
  assign admit = (scan_q < loaded_q) && !adm_q[si] && ({5'd0, arr_mem[si]} <= now_q);
  assign tat   = now_q - {5'd0, arr_mem[cur_q]};
  assign wt    = tat - {5'd0, bur_mem[cur_q]};

  assign sts_o.scan_done   = (scan_q >= loaded_q);
  assign sts_o.fifo_empty  = (cnt_q == '0);
  assign sts_o.cur_done    = !cur_live_q || (cur_rem_q <= q_eff);
  assign sts_o.all_done    = (done_q >= loaded_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && loaded_q < CntW'(MaxProcs)) begin
      arr_mem[loaded_q[IdxW-1:0]] <= arrival_i;
      bur_mem[loaded_q[IdxW-1:0]] <= burst_i;
      rem_mem[loaded_q[IdxW-1:0]] <= burst_i;
    end
    if (cmd_i.run && cur_rem_q > q_eff) rem_mem[cur_q] <= cur_rem_q - q_eff;
    if (cmd_i.scan_step && admit) begin
      fifo_mem[head_q + cnt_q[IdxW-1:0]] <= si;
    end else if (cmd_i.push_cur) begin
      fifo_mem[head_q + cnt_q[IdxW-1:0]] <= cur_q;
    end
    if (cmd_i.pop) begin
      cur_q     <= fifo_mem[head_q];
      cur_rem_q <= rem_mem[fifo_mem[head_q]];
    end
    if (cmd_i.finish) begin
      job_id_o      <= 5'(cur_q) + 5'd1;
      job_arrival_o <= arr_mem[cur_q];
      job_burst_o   <= bur_mem[cur_q];
      wait_time_o   <= wt;
      turnaround_o  <= tat;
      last_result_o <= (done_q + 1'b1 == loaded_q);
      total_wait_o       <= (done_q + 1'b1 == loaded_q) ? sw_q + SumW'(wt) : '0;
      total_turnaround_o <= (done_q + 1'b1 == loaded_q) ? st_q + SumW'(tat) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adm_q <= '0; head_q <= '0; cnt_q <= '0; loaded_q <= '0; done_q <= '0;
      now_q <= '0; sw_q <= '0; st_q <= '0; scan_q <= '0; cur_live_q <= 1'b0;
      min_q <= '0; min_ok_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        adm_q <= '0; head_q <= '0; cnt_q <= '0; loaded_q <= '0; done_q <= '0;
        now_q <= '0; sw_q <= '0; st_q <= '0;
      end
      if (cmd_i.load && loaded_q < CntW'(MaxProcs)) loaded_q <= loaded_q + 1'b1;
      if (cmd_i.scan_start || cmd_i.min_start) scan_q <= '0;
      if (cmd_i.min_start) min_ok_q <= 1'b0;
      if (cmd_i.scan_step) begin
        if (!sts_o.scan_done) scan_q <= scan_q + 1'b1;
        if (admit) begin
          adm_q[si] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.min_step && !sts_o.scan_done) begin
        scan_q <= scan_q + 1'b1;
        if (!adm_q[si] && (!min_ok_q || {5'd0, arr_mem[si]} < min_q)) begin
          min_q    <= {5'd0, arr_mem[si]};
          min_ok_q <= 1'b1;
        end
      end
      if (cmd_i.jump) now_q <= min_q;
      if (cmd_i.push_cur) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.pop) begin
        head_q <= head_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
        cur_live_q <= 1'b1;
      end
      if (cmd_i.run) begin
        if (cur_rem_q > q_eff) begin
          now_q <= now_q + TimeW'(q_eff);
        end else begin
          now_q <= now_q + TimeW'(cur_rem_q);
          cur_live_q <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        done_q <= done_q + 1'b1;
        sw_q <= sw_q + SumW'(wt);
        st_q <= st_q + SumW'(tat);
      end
    end
  end
endmodule

### sv/round_robin_schedule_sim_top.sv
// Top level: round-robin schedule simulator
// Channel | Dir | Beat contents
// s_axis  | in  | tdata {burst, arrival}, tlast is_last
// m_axis  | out | tdata job fields, tuser last_result
// cfg     | in  | quantum write
// Load beats are taken while idle; the last beat starts an admit scan over all n loaded jobs.
// A preempting turn runs choose, pop, run and an admit scan.
// A finishing turn runs choose, pop, run, a finish step, an admit scan and emit.
// An empty queue adds choose, a minimum search and an admit scan.
// Results wait in the output register; the schedule stalls until taken.
// Reset clears the job set and sets the quantum to 4.
module round_robin_schedule_sim_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // arrival, burst
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // job_id, job_arrival, job_burst, wait_time,
                                      // turnaround, total_wait, total_turnaround
  output logic         m_axis_tuser   // last_result
);
  import rrs_pkg::*;

  logic [15:0] quantum_q;
  rrs_cmd_t    cmd;
  rrs_sts_t    sts;
  logic [4:0]  id;
  logic [15:0] arr, bur;
  logic [20:0] wt, tat;
  logic [24:0] tw, tt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= 16'd4;
    else if (cfg_we_i) quantum_q <= cfg_wdata_i;
  end

  rrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  rrs_dp u_dp (
    .clk_i, .rst_ni, .quantum_i(quantum_q),
    .arrival_i(s_axis_tdata[15:0]), .burst_i(s_axis_tdata[31:16]),
    .cmd_i(cmd), .sts_o(sts),
    .job_id_o(id), .job_arrival_o(arr), .job_burst_o(bur),
    .wait_time_o(wt), .turnaround_o(tat), .total_wait_o(tw),
    .total_turnaround_o(tt), .last_result_o(m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, tt, tw, tat, wt, bur, arr, id};

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("load while emitting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");
endmodule

### tb/rrs_sched_checker.sv
// Checker: predicts round-robin completion order and compares every result beat
`timescale 1ns / 1ps
module rrs_sched_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count,
  output int           pending,
  output int           jobs_seen
);
  import rrs_pkg::*;

  typedef struct packed {
    logic [4:0]  id;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [20:0] wt;
    logic [20:0] tat;
    logic [24:0] tot_wt;
    logic [24:0] tot_tat;
    logic        last;
  } job_done_t;

  logic [15:0]      quantum;
  logic [15:0]      arr_tab[MaxProcs];
  logic [15:0]      burst_tab[MaxProcs];
  logic [15:0]      left_tab[MaxProcs];
  logic [MaxProcs-1:0] in_queue;
  int               n_loaded;
  logic [20:0]      now;
  int               ready_q[$];
  job_done_t        done_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void admit_arrived();
    for (int i = 0; i < n_loaded; i++) begin
      if (!in_queue[i] && {5'd0, arr_tab[i]} <= now) begin
        in_queue[i] = 1'b1;
        ready_q.push_back(i);
      end
    end
  endfunction

  task automatic run_schedule();
    logic [15:0] q;
    logic [20:0] tat, wt;
    logic [24:0] sw, st;
    logic [16:0] soonest;
    int          j, finished;
    q = (quantum == 16'd0) ? 16'd1 : quantum;
    sw = '0; st = '0; finished = 0;
    admit_arrived();
    while (finished < n_loaded) begin
      if (ready_q.size() == 0) begin
        soonest = 17'h1ffff;
        for (int i = 0; i < n_loaded; i++)
          if (!in_queue[i] && {1'b0, arr_tab[i]} < soonest) soonest = {1'b0, arr_tab[i]};
        now = {4'd0, soonest};
        admit_arrived();
        continue;
      end
      j = ready_q.pop_front();
      if (left_tab[j] > q) begin
        now = now + {5'd0, q};
        left_tab[j] = left_tab[j] - q;
        admit_arrived();
        ready_q.push_back(j);
      end else begin
        now = now + {5'd0, left_tab[j]};
        left_tab[j] = '0;
        tat = now - {5'd0, arr_tab[j]};
        wt = tat - {5'd0, burst_tab[j]};
        st = st + {4'd0, tat};
        sw = sw + {4'd0, wt};
        admit_arrived();
        done_q.push_back('{id: 5'(j + 1), arr: arr_tab[j], burst: burst_tab[j], wt: wt,
                           tat: tat, tot_wt: '0, tot_tat: '0, last: 1'b0});
        finished++;
      end
    end
    if (n_loaded > 0) begin
      done_q[done_q.size()-1].tot_wt = sw;
      done_q[done_q.size()-1].tot_tat = st;
      done_q[done_q.size()-1].last = 1'b1;
    end
    n_loaded = 0; in_queue = '0; now = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    job_done_t w;
    if (!rst_ni) begin
      quantum = 16'd4;
      n_loaded = 0;
      in_queue = '0;
      now = '0;
      ready_q.delete();
      done_q.delete();
      fail_count = 0;
      jobs_seen = 0;
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (done_q.size() == 0) begin
          report("unexpected beat, job_id", 32'(m_axis_tdata[4:0]), 0);
        end else begin
          w = done_q.pop_front();
          jobs_seen++;
          if (m_axis_tdata[4:0] !== w.id)
            report("job_id", 32'(m_axis_tdata[4:0]), 32'(w.id));
          if (m_axis_tdata[20:5] !== w.arr)
            report("job_arrival", 32'(m_axis_tdata[20:5]), 32'(w.arr));
          if (m_axis_tdata[36:21] !== w.burst)
            report("job_burst", 32'(m_axis_tdata[36:21]), 32'(w.burst));
          if (m_axis_tdata[57:37] !== w.wt)
            report("wait_time", 32'(m_axis_tdata[57:37]), 32'(w.wt));
          if (m_axis_tdata[78:58] !== w.tat)
            report("turnaround", 32'(m_axis_tdata[78:58]), 32'(w.tat));
          if (m_axis_tdata[103:79] !== w.tot_wt)
            report("total_wait", 32'(m_axis_tdata[103:79]), 32'(w.tot_wt));
          if (m_axis_tdata[128:104] !== w.tot_tat)
            report("total_turnaround", 32'(m_axis_tdata[128:104]), 32'(w.tot_tat));
          if (m_axis_tuser !== w.last)
            report("last_result", 32'(m_axis_tuser), 32'(w.last));
        end
      end
      if (cfg_we_i) quantum = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (n_loaded < MaxProcs) begin
          arr_tab[n_loaded] = s_axis_tdata[15:0];
          burst_tab[n_loaded] = s_axis_tdata[31:16];
          left_tab[n_loaded] = s_axis_tdata[31:16];
          n_loaded++;
        end
        if (s_axis_tlast) run_schedule();
      end
      pending = done_q.size();
    end
  end
endmodule

### tb/tb_round_robin_schedule_sim_top.sv
// Testbench top: job-set stimulus, idling phases and the verdict
`timescale 1ns / 1ps
module tb_round_robin_schedule_sim_top;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count, pending, jobs_seen;
  int           send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
  int           beats_sent = 0, sets_sent = 0;
  logic [15:0]  cur_quantum = 16'd4;

  always #4 clk_i = ~clk_i;

  round_robin_schedule_sim_top u_dut (.*);

  rrs_sched_checker u_chk (.*);

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("[round_robin_schedule_sim_top] ERROR");
    $finish;
  end

  task automatic send_job(input logic [15:0] arr, input logic [15:0] burst, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {burst, arr};
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_quantum(input logic [15:0] q);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = q;
    cur_quantum = q;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_random_set(input int n);
    logic [15:0] arr, burst;
    logic [15:0] bmax;
    int          spread;
    bmax = (cur_quantum > 16'd16383) ? 16'hffff : cur_quantum * 16'd4;
    spread = ($urandom_range(9) == 0) ? 65535 : $urandom_range(60);
    for (int i = 0; i < n; i++) begin
      arr = 16'($urandom_range(spread));
      burst = 16'($urandom_range(bmax, 1));
      send_job(arr, burst, i == n - 1);
    end
    sets_sent++;
  endtask

  initial begin
    logic [15:0] q;
    int          n;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_job(16'd0, 16'd1, 1'b0);
    send_job(16'd0, 16'd5, 1'b0);
    send_job(16'd3, 16'd2, 1'b1);
    send_job(16'd100, 16'd3, 1'b0);
    send_job(16'd0, 16'd2, 1'b1);
    drain_and_set_quantum(16'hffff);
    send_job(16'hffff, 16'hffff, 1'b0);
    send_job(16'h0000, 16'hffff, 1'b1);
    drain_and_set_quantum(16'd1);
    for (int i = 0; i < 17; i++) send_job(16'(i * 3), 16'(i % 4 + 1), i == 16);
    sets_sent += 4;

    for (int s = 0; beats_sent < 215; s++) begin
      case ($urandom_range(5))
        0: q = 16'd1;
        1: q = 16'hffff;
        2: q = 16'd4;
        default: q = 16'($urandom_range(65535, 1));
      endcase
      drain_and_set_quantum(q);
      case ((s / 3) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      n = ($urandom_range(4) == 0) ? $urandom_range(18, 8) : $urandom_range(6, 1);
      if (s == 5) begin
        hold_cycles = 400;
        send_idle_pct = 0;
        send_random_set(16);
        send_random_set(4);
      end else begin
        send_random_set(n);
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Ran %0d job sets, %0d load beats, %0d finished-job beats checked.",
             sets_sent, beats_sent, jobs_seen);
    $display("Quantum swept from 1 to 65535 across four idling phases.");
    if (fail_count == 0) begin
      $display("[round_robin_schedule_sim_top] OK");
    end else begin
      $display("[round_robin_schedule_sim_top] ERROR");
    end
    $finish;
  end
endmodule
